/* rtl/cce_pkg.sv */
// Shared codes for the conic curve evaluator: curve kinds, register indexes
// and response flag positions. No dependencies.
package cce_pkg;
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_LINE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ELLIPSE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HYPERBOLA = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_KIND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B     = 2'd2;

   localparam int RSP_USER_W   = 2;
   localparam int RSP_OOR_BIT  = 0;
   localparam int RSP_SAT_BIT  = 1;
endpackage

/* rtl/cce_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// Standalone; used by conic_curve_evaluator.
module cce_mul #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [WIDTH-1:0]     op_a,
   input  logic [WIDTH-1:0]     op_b,
   output logic [2*WIDTH-1:0]   product
);
   localparam int LO_W = (WIDTH + 1) / 2;
   localparam int HI_W = WIDTH - LO_W;

   logic [2*LO_W-1:0]      ll_ff;
   logic [LO_W+HI_W-1:0]   lh_ff;
   logic [LO_W+HI_W-1:0]   hl_ff;
   logic [2*HI_W-1:0]      hh_ff;
   logic [2*WIDTH-1:0]     sum_in;
   logic [2*WIDTH-1:0]     product_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff <= op_a[LO_W-1:0] * op_b[LO_W-1:0];
         lh_ff <= op_a[LO_W-1:0] * op_b[WIDTH-1:LO_W];
         hl_ff <= op_a[WIDTH-1:LO_W] * op_b[LO_W-1:0];
         hh_ff <= op_a[WIDTH-1:LO_W] * op_b[WIDTH-1:LO_W];
      end
   end

   always_comb begin
      sum_in = (2*WIDTH)'(ll_ff)
             + ((2*WIDTH)'(lh_ff) << LO_W)
             + ((2*WIDTH)'(hl_ff) << LO_W)
             + ((2*WIDTH)'(hh_ff) << (2*LO_W));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= sum_in;
      end
   end

   assign product = product_ff;
endmodule

/* rtl/conic_curve_evaluator.sv */
// Conic curve evaluator: line, ellipse or hyperbola ordinate per abscissa.
// Pipeline depth is set by the bit-serial square root and divider stages,
// one bit per stage.
// Throughput: one request per cycle; every stage stalls together on rsp_tready.
// Reset (synchronous, active high): clears valid bits and the curve registers.
// Depends on cce_pkg and cce_mul.
module conic_curve_evaluator
   import cce_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [DATA_WIDTH-1:0]         csr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // x_value
   input  logic [((DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // y_value
   output logic [((DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // off_domain, saturated
   output logic [RSP_USER_W-1:0]         rsp_tuser
);
   localparam int W      = DATA_WIDTH;
   localparam int TD_W   = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int S_PRE  = 3;
   localparam int S_BM2  = S_PRE + W + 2;
   localparam int S_DV0  = S_PRE + W + 3;
   localparam int S_OUT  = S_DV0 + W + 1;
   localparam int NSB    = S_OUT + 1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              na;
      logic              nx;
      logic              nb;
      logic              oor;
      logic              over;
      logic [W-1:0]      a_mag;
      logic [W-1:0]      b_mag;
      logic [W-1:0]      x_mag;
      logic [W-1:0]      y;
      logic              sat;
   } sb_type;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? W'(~v + 1'b1) : v;
   endfunction

   // configuration
   logic [KIND_W-1:0] kind_ff;
   logic [W-1:0]      coef_a_ff;
   logic [W-1:0]      coef_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_LINE;
         coef_a_ff <= '0;
         coef_b_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CURVE_KIND: kind_ff   <= csr_data[KIND_W-1:0];
            CSR_COEF_A:     coef_a_ff <= csr_data;
            CSR_COEF_B:     coef_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NSB-1:0] v_ff;
   logic           adv;
   sb_type         sb_ff [0:NSB-1];
   sb_type         sb_in [0:NSB-1];

   assign adv        = !v_ff[S_OUT] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NSB-2:0], req_tvalid};
      end
   end

   // multipliers: a*x or a*a, and x*x
   logic [2*W-1:0] m1;
   logic [2*W-1:0] m2;
   logic [W-1:0]   m1_b;

   assign m1_b = (sb_ff[0].kind == KIND_LINE) ? sb_ff[0].x_mag : sb_ff[0].a_mag;

   cce_mul #(.WIDTH(W)) u_mul_ax (
      .clock(clock), .enable(adv),
      .op_a(sb_ff[0].a_mag), .op_b(m1_b), .product(m1)
   );

   cce_mul #(.WIDTH(W)) u_mul_xx (
      .clock(clock), .enable(adv),
      .op_a(sb_ff[0].x_mag), .op_b(sb_ff[0].x_mag), .product(m2)
   );

   // line result and conic domain check
   logic [2*W-1:0]      shifted;
   logic [W+1:0]        lo_mag;
   logic signed [W+2:0] s_term;
   logic signed [W+2:0] b_term;
   logic signed [W+2:0] line_sum;
   logic [W-1:0]        line_y;
   logic                line_sat;
   logic                pre_oor;
   logic [2*W-1:0]      pre_d;

   always_comb begin
      shifted = m1 >> FRAC_BITS;
      if ((shifted >> (W + 2)) != '0 || shifted[W+1:0] > {1'b1, {(W+1){1'b0}}}) begin
         lo_mag = {1'b1, {(W+1){1'b0}}};
      end else begin
         lo_mag = shifted[W+1:0];
      end
      s_term = $signed({1'b0, lo_mag});
      if (sb_ff[2].na != sb_ff[2].nx) s_term = -s_term;
      b_term = $signed({3'b000, sb_ff[2].b_mag});
      if (sb_ff[2].nb) b_term = -b_term;
      line_sum = s_term + b_term;
      line_sat = 1'b0;
      line_y   = line_sum[W-1:0];
      if (line_sum > $signed({4'b0000, {(W-1){1'b1}}})) begin
         line_y   = {1'b0, {(W-1){1'b1}}};
         line_sat = 1'b1;
      end else if (line_sum < $signed({4'b1111, {(W-1){1'b0}}})) begin
         line_y   = {1'b1, {(W-1){1'b0}}};
         line_sat = 1'b1;
      end

      pre_oor = 1'b0;
      pre_d   = '0;
      case (sb_ff[2].kind)
         KIND_LINE: pre_oor = 1'b0;
         KIND_ELLIPSE: begin
            pre_oor = (sb_ff[2].a_mag == '0) || (sb_ff[2].x_mag > sb_ff[2].a_mag);
            if (!pre_oor) pre_d = m1 - m2;
         end
         KIND_HYPERBOLA: begin
            pre_oor = (sb_ff[2].a_mag == '0) || (sb_ff[2].x_mag < sb_ff[2].a_mag);
            if (!pre_oor) pre_d = m2 - m1;
         end
         default: pre_oor = 1'b1;
      endcase
   end

   // square root, one root bit per stage
   logic [2*W-1:0] sq_rem_ff  [0:W];
   logic [W-1:0]   sq_root_ff [0:W];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= pre_d;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar g = 0; g < W; g++) begin : g_sqrt
      localparam int I = W - 1 - g;
      logic [2*W:0]   trial;
      logic [2*W-1:0] rem_n;
      logic [W-1:0]   root_n;

      always_comb begin
         trial = ({{(W+1){1'b0}}, sq_root_ff[g]} << (I + 1))
               | ({{(2*W){1'b0}}, 1'b1} << (2 * I));
         rem_n  = sq_rem_ff[g];
         root_n = sq_root_ff[g];
         if ({1'b0, sq_rem_ff[g]} >= trial) begin
            rem_n  = sq_rem_ff[g] - trial[2*W-1:0];
            root_n = sq_root_ff[g] | ({{(W-1){1'b0}}, 1'b1} << I);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[g+1]  <= rem_n;
            sq_root_ff[g+1] <= root_n;
         end
      end
   end

   // |b| * root
   logic [2*W-1:0] bs;

   cce_mul #(.WIDTH(W)) u_mul_bs (
      .clock(clock), .enable(adv),
      .op_a(sb_ff[S_PRE+W].b_mag), .op_b(sq_root_ff[W]), .product(bs)
   );

   // divide by |a|, one quotient bit per stage
   logic [W-1:0] dv_rem_ff [0:W];
   logic [W-1:0] dv_q_ff   [0:W];
   logic [W-1:0] dv_lo_ff  [0:W];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= bs[2*W-1:W];
         dv_q_ff[0]   <= '0;
         dv_lo_ff[0]  <= bs[W-1:0];
      end
   end

   for (genvar g = 0; g < W; g++) begin : g_div
      logic [W:0]   trial;
      logic [W-1:0] rem_n;
      logic [W-1:0] q_n;

      always_comb begin
         trial = {dv_rem_ff[g], dv_lo_ff[g][W-1]};
         rem_n = trial[W-1:0];
         q_n   = {dv_q_ff[g][W-2:0], 1'b0};
         if (trial >= {1'b0, sb_ff[S_DV0+g].a_mag}) begin
            rem_n = W'(trial - {1'b0, sb_ff[S_DV0+g].a_mag});
            q_n   = {dv_q_ff[g][W-2:0], 1'b1};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[g+1] <= rem_n;
            dv_q_ff[g+1]   <= q_n;
            dv_lo_ff[g+1]  <= {dv_lo_ff[g][W-2:0], 1'b0};
         end
      end
   end

   // sideband per stage
   logic [W-1:0] q_fin;

   assign q_fin = dv_q_ff[W];

   always_comb begin
      sb_in[0].kind  = kind_ff;
      sb_in[0].na    = coef_a_ff[W-1];
      sb_in[0].nx    = req_tdata[W-1];
      sb_in[0].nb    = coef_b_ff[W-1];
      sb_in[0].oor   = 1'b0;
      sb_in[0].over  = 1'b0;
      sb_in[0].a_mag = mag(coef_a_ff);
      sb_in[0].b_mag = mag(coef_b_ff);
      sb_in[0].x_mag = mag(req_tdata[W-1:0]);
      sb_in[0].y     = '0;
      sb_in[0].sat   = 1'b0;
      for (int k = 1; k < NSB; k++) begin
         sb_in[k] = sb_ff[k-1];
      end

      sb_in[S_PRE].oor = pre_oor;
      sb_in[S_PRE].y   = line_y;
      sb_in[S_PRE].sat = line_sat;

      // quotient would reach 2^W: clip
      sb_in[S_DV0].over = (bs[2*W-1:W] >= sb_ff[S_BM2].a_mag);

      if (sb_ff[S_OUT-1].oor) begin
         sb_in[S_OUT].y   = '0;
         sb_in[S_OUT].sat = 1'b0;
      end else if (sb_ff[S_OUT-1].kind != KIND_LINE) begin
         if (sb_ff[S_OUT-1].nb) begin
            if (sb_ff[S_OUT-1].over || q_fin > {1'b1, {(W-1){1'b0}}}) begin
               sb_in[S_OUT].y   = {1'b1, {(W-1){1'b0}}};
               sb_in[S_OUT].sat = 1'b1;
            end else begin
               sb_in[S_OUT].y   = W'(~q_fin + 1'b1);
               sb_in[S_OUT].sat = 1'b0;
            end
         end else begin
            if (sb_ff[S_OUT-1].over || q_fin[W-1]) begin
               sb_in[S_OUT].y   = {1'b0, {(W-1){1'b1}}};
               sb_in[S_OUT].sat = 1'b1;
            end else begin
               sb_in[S_OUT].y   = q_fin;
               sb_in[S_OUT].sat = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NSB; k++) begin
            sb_ff[k] <= sb_in[k];
         end
      end
   end

   assign rsp_tvalid             = v_ff[S_OUT];
   assign rsp_tdata              = TD_W'(sb_ff[S_OUT].y);
   assign rsp_tuser[RSP_OOR_BIT] = sb_ff[S_OUT].oor;
   assign rsp_tuser[RSP_SAT_BIT] = sb_ff[S_OUT].sat;

`ifndef SYNTHESIS
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[RSP_OOR_BIT] |->
         rsp_tdata[W-1:0] == '0 && !rsp_tuser[RSP_SAT_BIT])
      else $error("out of range response carries data");

   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_PRE+W] |-> sq_rem_ff[W] <= (2*W)'({sq_root_ff[W], 1'b0}))
      else $error("square root remainder too large");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      v_ff[S_DV0+W] && !sb_ff[S_DV0+W].oor && sb_ff[S_DV0+W].kind != KIND_LINE
         && !sb_ff[S_DV0+W].over |-> dv_rem_ff[W] < sb_ff[S_DV0+W].a_mag)
      else $error("divider remainder not below divisor");
`endif
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for conic_curve_evaluator: predicts line, ellipse and
// hyperbola ordinates per request and checks every response. Depends on cce_pkg.
module tb_top
   import cce_pkg::*;
();

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int LATENCY    = 2*DATA_WIDTH+8;
   localparam int WATCHDOG   = 20000;
   localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
   localparam logic signed [63:0] NEG_MIN = -64'sd2147483648;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] y;
      logic        oor;
      logic        sat;
   } ordinate_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_CURVE_KIND;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   conic_curve_evaluator #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) dut (.*);

   initial forever #5 clock = ~clock;

   logic [1:0]   cur_kind;
   logic [31:0]  cur_a, cur_b;
   logic [31:0]  x_pending[$];
   ordinate_type ordinates_due[$];
   int           errors = 0;
   bit           quiet = 0;
   bit           sender_idle_ok = 1;
   bit           hold_long = 0;
   int           rx_hold = 0;
   int           tx_gap = 0;
   int           idle_cycles = 0;

   function automatic logic [63:0] mag32(logic [31:0] v);
      return v[31] ? 64'(-$signed({v[31], v})) : 64'(v);
   endfunction

   function automatic logic [63:0] isqrt128(logic [127:0] d);
      logic [63:0] r, t;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (128'(t) * 128'(t) <= d) r = t;
      end
      return r;
   endfunction

   function automatic ordinate_type predict_ordinate(logic [31:0] x);
      ordinate_type o;
      logic [63:0] am, bm, xm, s;
      logic [127:0] p, q;
      logic signed [63:0] sum, term;
      am = mag32(cur_a);
      bm = mag32(cur_b);
      xm = mag32(x);
      o = '0;
      case (cur_kind)
         KIND_LINE: begin
            p = (128'(am) * 128'(xm)) >> FRAC_BITS;
            if (p > (128'd1 << 33)) p = 128'd1 << 33;
            term = $signed(p[63:0]);
            if (cur_a[31] != x[31]) term = -term;
            sum = term + $signed(64'($signed(cur_b)));
            if (sum > POS_MAX) begin sum = POS_MAX; o.sat = 1; end
            else if (sum < NEG_MIN) begin sum = NEG_MIN; o.sat = 1; end
            o.y = sum[31:0];
         end
         KIND_ELLIPSE, KIND_HYPERBOLA: begin
            if (am == 0 || (cur_kind == KIND_ELLIPSE && xm > am) ||
                (cur_kind == KIND_HYPERBOLA && xm < am)) o.oor = 1;
            else begin
               s = isqrt128(cur_kind == KIND_ELLIPSE ? am*am - xm*xm : xm*xm - am*am);
               q = (128'(bm) * 128'(s)) / 128'(am);
               if (cur_b[31]) begin
                  if (q > 128'h8000_0000) begin q = 128'h8000_0000; o.sat = 1; end
                  o.y = -q[31:0];
               end else begin
                  if (q > 128'h7fff_ffff) begin q = 128'h7fff_ffff; o.sat = 1; end
                  o.y = q[31:0];
               end
            end
         end
         default: o.oor = 1;
      endcase
      return o;
   endfunction

   // driver: predict at acceptance so config stays coherent with each request
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ordinates_due.push_back(predict_ordinate(req_tdata));
         void'(x_pending.pop_front());
      end
      if (req_tvalid && !req_tready) begin
         // hold the offered request until it is taken
      end else if (tx_gap > 0) begin
         tx_gap <= tx_gap - 1;
         req_tvalid <= 0;
      end else if (!quiet && sender_idle_ok && $urandom_range(0, 9) == 0) begin
         tx_gap <= $urandom_range(1, 17);
         req_tvalid <= 0;
      end else begin
         automatic int n = (req_tvalid && req_tready) ? 1 : 0;
         if (x_pending.size() > n) begin
            req_tvalid <= 1;
            req_tdata <= x_pending[n];
         end else req_tvalid <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (ordinates_due.size() == 0) begin
               $display("%0t unexpected response y=%h user=%b", $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               automatic ordinate_type e = ordinates_due.pop_front();
               if (e.y !== rsp_tdata || e.oor !== rsp_tuser[RSP_OOR_BIT] ||
                   e.sat !== rsp_tuser[RSP_SAT_BIT]) begin
                  $display("%0t mismatch expected y=%h oor=%b sat=%b actual y=%h oor=%b sat=%b",
                           $time, e.y, e.oor, e.sat, rsp_tdata,
                           rsp_tuser[RSP_OOR_BIT], rsp_tuser[RSP_SAT_BIT]);
                  errors++;
               end
            end
         end
         if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            rsp_tready <= 0;
         end else if (hold_long) begin
            // long hold while the sender keeps offering
            hold_long = 0;
            rx_hold <= 400;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_hold <= $urandom_range(1, 17);
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_CURVE_KIND: cur_kind = val[1:0];
         CSR_COEF_A:     cur_a = val;
         default:        cur_b = val;
      endcase
      @(posedge clock);
   endtask

   task automatic settle;
      while (x_pending.size() != 0 || ordinates_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(int shape);
      case (shape)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      endcase
   endfunction

   task automatic run_phase(logic [1:0] kind, logic [31:0] a, logic [31:0] b, int n);
      write_reg(CSR_CURVE_KIND, 32'(kind));
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: x_pending.push_back(a);
            1: x_pending.push_back(-a + $urandom_range(0, 2) - 1);
            default: x_pending.push_back(rand_word($urandom_range(0, 3)));
         endcase
      end
      settle();
   endtask

   initial begin
      cur_kind = KIND_LINE;
      cur_a = 0;
      cur_b = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: field extremes per kind, domain edges, zero a, unused kind
      run_phase(KIND_LINE, 32'h7fffffff, 32'h7fffffff, 0);
      x_pending.push_back(32'h0); x_pending.push_back(32'h7fffffff);
      x_pending.push_back(32'h80000000); x_pending.push_back(32'h1);
      x_pending.push_back(32'hffffffff);
      settle();
      run_phase(KIND_LINE, 32'h80000000, 32'h80000000, 0);
      x_pending.push_back(32'h7fffffff); x_pending.push_back(32'h80000000);
      x_pending.push_back(32'h0);
      settle();
      run_phase(KIND_ELLIPSE, 32'h00030000, 32'h80000000, 0);
      x_pending.push_back(32'h00030000); x_pending.push_back(32'hfffd0000);
      x_pending.push_back(32'h0); x_pending.push_back(32'h00030001);
      x_pending.push_back(32'h80000000);
      settle();
      run_phase(KIND_HYPERBOLA, 32'h00000001, 32'h7fffffff, 0);
      x_pending.push_back(32'h1); x_pending.push_back(32'h0);
      x_pending.push_back(32'h7fffffff); x_pending.push_back(32'h80000000);
      x_pending.push_back(32'hffffffff);
      settle();
      run_phase(KIND_ELLIPSE, 32'h0, 32'h00010000, 0);
      x_pending.push_back(32'h0); x_pending.push_back(32'h5);
      settle();
      run_phase(KIND_UNUSED, 32'h00010000, 32'h00010000, 0);
      x_pending.push_back(32'h0); x_pending.push_back(32'h12345678);
      settle();
      // long receiver stall while the sender keeps offering requests
      write_reg(CSR_CURVE_KIND, 32'(KIND_ELLIPSE));
      for (int i = 0; i < 150; i++) x_pending.push_back(rand_word(3));
      sender_idle_ok = 0;
      hold_long = 1;
      settle();
      sender_idle_ok = 1;
      // random phases
      for (int ph = 0; ph < 18; ph++) begin
         automatic logic [1:0] k = (ph % 8 == 7) ? KIND_UNUSED : 2'($urandom_range(0, 2));
         if (ph == 14) quiet = 1;
         run_phase(k, rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)), 55);
      end
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

/* conic_curve_evaluator.f */
rtl/cce_pkg.sv
rtl/cce_mul.sv
rtl/conic_curve_evaluator.sv
dv/tb_top.sv
